/* hw/rtl/lmrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner package
// Field widths, operation codes and default panel geometry.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  localparam int PanelWidthDef  = 64;
  localparam int PanelHeightDef = 32;

  localparam int OpW     = 2;
  localparam int CoordW  = 8;
  localparam int ColorW  = 8;
  localparam int RowAdrW = 4;
  localparam int ColIdxW = 6;
  localparam int SlotW   = 3;

  localparam logic [OpW-1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [OpW-1:0] OP_FILL      = 2'd1;
  localparam logic [OpW-1:0] OP_TICK      = 2'd2;

  // Bit positions of the stored slots.
  localparam int SLOT_BLUE  = 0;
  localparam int SLOT_RED   = 1;
  localparam int SLOT_GREEN = 2;

endpackage

/* hw/rtl/lmrs_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner input channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface lmrs_item_if;
  logic                            valid;
  logic                            ready;
  logic [lmrs_pkg::OpW-1:0]        operation;
  logic [lmrs_pkg::CoordW-1:0]     pixel_x;
  logic [lmrs_pkg::CoordW-1:0]     pixel_y;
  logic [lmrs_pkg::ColorW-1:0]     red_in;
  logic [lmrs_pkg::ColorW-1:0]     green_in;
  logic [lmrs_pkg::ColorW-1:0]     blue_in;

  modport source (
    output valid, operation, pixel_x, pixel_y, red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_x, pixel_y, red_in, green_in, blue_in,
    output ready
  );
endinterface

/* hw/rtl/lmrs_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner output channel
// Valid/ready channel carrying one shifted column word.
// ----------------------------------------------------------------------------
interface lmrs_result_if;
  logic                          valid;
  logic                          ready;
  logic [lmrs_pkg::RowAdrW-1:0]  row_address;
  logic [lmrs_pkg::ColIdxW-1:0]  column_index;
  logic                          top_red_pin;
  logic                          top_green_pin;
  logic                          top_blue_pin;
  logic                          bottom_red_pin;
  logic                          bottom_green_pin;
  logic                          bottom_blue_pin;
  logic                          latch_now;

  modport source (
    output valid, row_address, column_index, top_red_pin, top_green_pin,
           top_blue_pin, bottom_red_pin, bottom_green_pin, bottom_blue_pin,
           latch_now,
    input  ready
  );
  modport sink (
    input  valid, row_address, column_index, top_red_pin, top_green_pin,
           top_blue_pin, bottom_red_pin, bottom_green_pin, bottom_blue_pin,
           latch_now,
    output ready
  );
endinterface

/* hw/rtl/lmrs_frame_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner frame store
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lmrs_frame_store #(
  parameter int Depth = lmrs_pkg::PanelWidthDef * lmrs_pkg::PanelHeightDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [lmrs_pkg::SlotW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_a_i,
  input  logic [AddrW-1:0]           raddr_b_i,
  output logic [lmrs_pkg::SlotW-1:0] rdata_a_o,
  output logic [lmrs_pkg::SlotW-1:0] rdata_b_o
);

  logic [lmrs_pkg::SlotW-1:0] mem [Depth];
  logic [lmrs_pkg::SlotW-1:0] rdata_a_q;
  logic [lmrs_pkg::SlotW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data between reads so a stalled pipeline keeps its word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* hw/rtl/led_matrix_row_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner
// Drives a two-half-scan RGB panel from a 3-bit-per-pixel frame store.
// ----------------------------------------------------------------------------
// A tick accepted while scanning is enabled enters the scan state, whose
//   reads pass the registered two-port store read and the output register:
//   one column word per cycle while the output is not stalled. The input is
//   not ready during a scan or a fill sweep; set pixel and ignored items are
//   taken in idle. Fill rewrites all PANEL_WIDTH * PANEL_HEIGHT addresses.
// Reset: a clearing sweep over the whole store runs first.
module led_matrix_row_scanner #(
  parameter int PANEL_WIDTH  = lmrs_pkg::PanelWidthDef,
  parameter int PANEL_HEIGHT = lmrs_pkg::PanelHeightDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 scan_enable_we_i,
  input  logic                 scan_enable_wdata_i,
  lmrs_item_if.sink            item_i,
  lmrs_result_if.source        result_o
);

  localparam int Depth    = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int AddrW    = $clog2(Depth);
  localparam int Half     = PANEL_HEIGHT / 2;
  localparam int ColW     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam logic [ColW-1:0]  LastCol  = ColW'(PANEL_WIDTH - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [lmrs_pkg::RowAdrW-1:0] LastRow = lmrs_pkg::RowAdrW'(Half - 1);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]                       state_q, state_d;
  logic                             scan_enable_q;
  logic [AddrW-1:0]                 sweep_addr_q, sweep_addr_d;
  logic [lmrs_pkg::SlotW-1:0]       fill_color_q, fill_color_d;
  logic [lmrs_pkg::RowAdrW-1:0]     scan_row_q, scan_row_d;
  logic [ColW-1:0]                  col_q, col_d;

  logic                             s1_valid_q, s1_valid_d;
  logic [ColW-1:0]                  s1_col_q;
  logic [lmrs_pkg::RowAdrW-1:0]     s1_row_q;
  logic                             s1_last_q;

  logic                             out_valid_q, out_valid_d;
  logic [lmrs_pkg::RowAdrW-1:0]     out_row_q;
  logic [lmrs_pkg::ColIdxW-1:0]     out_col_q;
  logic [lmrs_pkg::SlotW-1:0]       out_top_q;
  logic [lmrs_pkg::SlotW-1:0]       out_bot_q;
  logic                             out_last_q;

  logic                             accept;
  logic                             in_range;
  logic [lmrs_pkg::SlotW-1:0]       in_color;
  logic                             issue;
  logic                             s1_adv;
  logic                             issue_last;

  logic                             mem_we;
  logic [AddrW-1:0]                 mem_waddr;
  logic [lmrs_pkg::SlotW-1:0]       mem_wdata;
  logic [AddrW-1:0]                 rd_addr_top;
  logic [AddrW-1:0]                 rd_addr_bot;
  logic [lmrs_pkg::SlotW-1:0]       rd_top;
  logic [lmrs_pkg::SlotW-1:0]       rd_bot;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;

  assign in_color[lmrs_pkg::SLOT_BLUE]  = |item_i.blue_in;
  assign in_color[lmrs_pkg::SLOT_RED]   = |item_i.red_in;
  assign in_color[lmrs_pkg::SLOT_GREEN] = |item_i.green_in;

  assign in_range = (item_i.pixel_x < lmrs_pkg::CoordW'(PANEL_WIDTH)) &&
                    (item_i.pixel_y < lmrs_pkg::CoordW'(PANEL_HEIGHT));

  // Store write: either the sweep or a single pixel from the input.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr_q;
    mem_wdata = fill_color_q;
    if (state_q == ST_SWEEP) begin
      mem_we = 1'b1;
    end else if (accept && (item_i.operation == lmrs_pkg::OP_SET_PIXEL) && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = AddrW'(AddrW'(item_i.pixel_y) * AddrW'(PANEL_WIDTH)) +
                  AddrW'(item_i.pixel_x);
      mem_wdata = in_color;
    end
  end

  // Column read pipeline: issue a read only when the read stage is free.
  assign s1_adv     = s1_valid_q && (!out_valid_q || result_o.ready);
  assign issue      = (state_q == ST_SCAN) && (!s1_valid_q || s1_adv);
  assign issue_last = issue && (col_q == LastCol);

  assign rd_addr_top = AddrW'(AddrW'(scan_row_q) * AddrW'(PANEL_WIDTH)) + AddrW'(col_q);
  assign rd_addr_bot = AddrW'((AddrW'(scan_row_q) + AddrW'(Half)) * AddrW'(PANEL_WIDTH)) +
                       AddrW'(col_q);

  lmrs_frame_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (issue),
    .raddr_a_i (rd_addr_top),
    .raddr_b_i (rd_addr_bot),
    .rdata_a_o (rd_top),
    .rdata_b_o (rd_bot)
  );

  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    fill_color_d = fill_color_q;
    scan_row_d   = scan_row_q;
    col_d        = col_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (item_i.operation == lmrs_pkg::OP_FILL) begin
            fill_color_d = in_color;
            sweep_addr_d = '0;
            state_d      = ST_SWEEP;
          end else if ((item_i.operation == lmrs_pkg::OP_TICK) && scan_enable_q) begin
            col_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          col_d = col_q + 1'b1;
          if (issue_last) begin
            state_d    = ST_IDLE;
            scan_row_d = (scan_row_q == LastRow) ? '0 : scan_row_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (issue) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SWEEP;
      sweep_addr_q  <= '0;
      fill_color_q  <= '0;
      scan_row_q    <= '0;
      col_q         <= '0;
      scan_enable_q <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      fill_color_q <= fill_color_d;
      scan_row_q   <= scan_row_d;
      col_q        <= col_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      if (scan_enable_we_i) begin
        scan_enable_q <= scan_enable_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_col_q  <= col_q;
      s1_row_q  <= scan_row_q;
      s1_last_q <= (col_q == LastCol);
    end
    if (s1_adv) begin
      out_row_q  <= s1_row_q;
      out_col_q  <= lmrs_pkg::ColIdxW'(s1_col_q);
      out_top_q  <= rd_top;
      out_bot_q  <= rd_bot;
      out_last_q <= s1_last_q;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.row_address      = out_row_q;
  assign result_o.column_index     = out_col_q;
  assign result_o.top_red_pin      = out_top_q[lmrs_pkg::SLOT_BLUE];
  assign result_o.top_green_pin    = out_top_q[lmrs_pkg::SLOT_RED];
  assign result_o.top_blue_pin     = out_top_q[lmrs_pkg::SLOT_GREEN];
  assign result_o.bottom_red_pin   = out_bot_q[lmrs_pkg::SLOT_BLUE];
  assign result_o.bottom_green_pin = out_bot_q[lmrs_pkg::SLOT_RED];
  assign result_o.bottom_blue_pin  = out_bot_q[lmrs_pkg::SLOT_GREEN];
  assign result_o.latch_now        = out_last_q;

  // A read is never issued while the store is being written.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && issue))
    else $error("store read and write in the same cycle");

  // A word waiting in the read stage stays until it moves to the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("read stage word dropped");

  // Latch marks only the last column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_last_q) |-> (out_col_q == lmrs_pkg::ColIdxW'(LastCol)))
    else $error("latch on a column other than the last");

  // The last column read ends the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   issue_last |=> (state_q == ST_IDLE))
    else $error("scan did not end after the last column");

endmodule

/* sim/lmrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner checker
// Follows the frame store, scan row and scan enable from the accepted
// operation words, and compares every column word against its prediction.
// ----------------------------------------------------------------------------
module lmrs_checker #(
  parameter int PANEL_WIDTH  = lmrs_pkg::PanelWidthDef,
  parameter int PANEL_HEIGHT = lmrs_pkg::PanelHeightDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   scan_enable_we_i,
  input  logic   scan_enable_wdata_i,
  lmrs_item_if   item_i,
  lmrs_result_if result_i,
  output int     mismatches_o,
  output int     pending_o
);

  localparam int HalfHeight = PANEL_HEIGHT / 2;
  localparam int StoreDepth = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int StoreAdrW  = $clog2(StoreDepth);

  typedef struct packed {
    logic [lmrs_pkg::RowAdrW-1:0] row_address;
    logic [lmrs_pkg::ColIdxW-1:0] column_index;
    logic                         top_red;
    logic                         top_green;
    logic                         top_blue;
    logic                         bottom_red;
    logic                         bottom_green;
    logic                         bottom_blue;
    logic                         latch;
  } column_word_t;

  logic [lmrs_pkg::SlotW-1:0]   frame_q [StoreDepth];
  logic [lmrs_pkg::RowAdrW-1:0] scan_row_q;
  logic                         scan_on_q;
  column_word_t                 expected_columns [$];
  int                           mismatch_count;

  function automatic logic [lmrs_pkg::SlotW-1:0] color_bits(
      logic [lmrs_pkg::ColorW-1:0] red,
      logic [lmrs_pkg::ColorW-1:0] green,
      logic [lmrs_pkg::ColorW-1:0] blue);
    logic [lmrs_pkg::SlotW-1:0] bits;
    bits                       = '0;
    bits[lmrs_pkg::SLOT_BLUE]  = |blue;
    bits[lmrs_pkg::SLOT_RED]   = |red;
    bits[lmrs_pkg::SLOT_GREEN] = |green;
    return bits;
  endfunction

  // Queue one word per column of the current row pair, then advance the row.
  task automatic shift_out_row();
    int                         row;
    logic [lmrs_pkg::SlotW-1:0] upper;
    logic [lmrs_pkg::SlotW-1:0] lower;
    column_word_t               word;
    row = int'(scan_row_q) % HalfHeight;
    for (int col = 0; col < PANEL_WIDTH; col++) begin
      upper             = frame_q[StoreAdrW'(row * PANEL_WIDTH + col)];
      lower             = frame_q[StoreAdrW'((row + HalfHeight) * PANEL_WIDTH + col)];
      word.row_address  = row[lmrs_pkg::RowAdrW-1:0];
      word.column_index = col[lmrs_pkg::ColIdxW-1:0];
      // Slots are wired crosswise: stored blue drives red, and so on.
      word.top_red      = upper[lmrs_pkg::SLOT_BLUE];
      word.top_green    = upper[lmrs_pkg::SLOT_RED];
      word.top_blue     = upper[lmrs_pkg::SLOT_GREEN];
      word.bottom_red   = lower[lmrs_pkg::SLOT_BLUE];
      word.bottom_green = lower[lmrs_pkg::SLOT_RED];
      word.bottom_blue  = lower[lmrs_pkg::SLOT_GREEN];
      word.latch        = (col == PANEL_WIDTH - 1);
      expected_columns.push_back(word);
    end
    scan_row_q = lmrs_pkg::RowAdrW'((row + 1) % HalfHeight);
  endtask

  function automatic string word_text(column_word_t word);
    return $sformatf("row %0d col %0d top rgb %b%b%b bottom rgb %b%b%b latch %b",
                     word.row_address, word.column_index, word.top_red,
                     word.top_green, word.top_blue, word.bottom_red,
                     word.bottom_green, word.bottom_blue, word.latch);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    column_word_t got;
    column_word_t want;
    if (!rst_ni) begin
      foreach (frame_q[i]) frame_q[i] = '0;
      scan_row_q     = '0;
      scan_on_q      = 1'b0;
      mismatch_count = 0;
      expected_columns.delete();
    end else begin
      if (result_i.valid && result_i.ready) begin
        got.row_address  = result_i.row_address;
        got.column_index = result_i.column_index;
        got.top_red      = result_i.top_red_pin;
        got.top_green    = result_i.top_green_pin;
        got.top_blue     = result_i.top_blue_pin;
        got.bottom_red   = result_i.bottom_red_pin;
        got.bottom_green = result_i.bottom_green_pin;
        got.bottom_blue  = result_i.bottom_blue_pin;
        got.latch        = result_i.latch_now;
        if (expected_columns.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected column word: expected none, got %s", $time,
                   word_text(got));
        end else begin
          want = expected_columns.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: column word mismatch: expected %s, got %s", $time,
                     word_text(want), word_text(got));
          end
        end
      end
      if (item_i.valid && item_i.ready) begin
        case (item_i.operation)
          lmrs_pkg::OP_SET_PIXEL: begin
            // Drop writes that fall off the panel.
            if (int'(item_i.pixel_x) < PANEL_WIDTH &&
                int'(item_i.pixel_y) < PANEL_HEIGHT) begin
              frame_q[StoreAdrW'(int'(item_i.pixel_y) * PANEL_WIDTH +
                                 int'(item_i.pixel_x))] =
                color_bits(item_i.red_in, item_i.green_in, item_i.blue_in);
            end
          end
          lmrs_pkg::OP_FILL: begin
            foreach (frame_q[i]) begin
              frame_q[i] = color_bits(item_i.red_in, item_i.green_in, item_i.blue_in);
            end
          end
          lmrs_pkg::OP_TICK: begin
            if (scan_on_q) shift_out_row();
          end
          default: ;
        endcase
      end
      // The block sees a new enable only from the next word on.
      if (scan_enable_we_i) begin
        scan_on_q = scan_enable_wdata_i;
      end
    end
    mismatches_o <= mismatch_count;
    pending_o    <= expected_columns.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix row scanner testbench
// Directed pixel, fill and scan cases, then random operation words over
// several scan enable settings, with random stalls on both channels and one
// long output stall that backs up the input. The checker does the compare.
// ----------------------------------------------------------------------------
module tb;

  localparam int Width       = lmrs_pkg::PanelWidthDef;
  localparam int Height      = lmrs_pkg::PanelHeightDef;
  localparam int FillCycles  = Width * Height;
  localparam int PauseCycles = FillCycles + 16;
  localparam int HoldCycles  = 400;
  localparam int TailCycles  = 200;
  localparam int IdleLimit   = 4 * FillCycles + 2 * HoldCycles;

  localparam logic [lmrs_pkg::OpW-1:0]    OpUnused  = 2'd3;
  localparam logic [lmrs_pkg::ColorW-1:0] ColorFull = '1;
  localparam logic [lmrs_pkg::ColorW-1:0] ColorOff  = '0;

  bit   clk_i;
  logic rst_ni;
  logic scan_enable_we;
  logic scan_enable_wdata;
  bit   quiet;
  int   hold_requests;
  int   mismatches;
  int   pending;

  lmrs_item_if   item_if ();
  lmrs_result_if result_if ();

  led_matrix_row_scanner #(
    .PANEL_WIDTH  (Width),
    .PANEL_HEIGHT (Height)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .scan_enable_we_i    (scan_enable_we),
    .scan_enable_wdata_i (scan_enable_wdata),
    .item_i              (item_if),
    .result_o            (result_if)
  );

  lmrs_checker #(
    .PANEL_WIDTH  (Width),
    .PANEL_HEIGHT (Height)
  ) i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .scan_enable_we_i    (scan_enable_we),
    .scan_enable_wdata_i (scan_enable_wdata),
    .item_i              (item_if),
    .result_i            (result_if),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the accept
  // with valid still high, so back-to-back words need no second assignment.
  task automatic send_word(logic [lmrs_pkg::OpW-1:0] op,
                           logic [lmrs_pkg::CoordW-1:0] x,
                           logic [lmrs_pkg::CoordW-1:0] y,
                           logic [lmrs_pkg::ColorW-1:0] red,
                           logic [lmrs_pkg::ColorW-1:0] green,
                           logic [lmrs_pkg::ColorW-1:0] blue);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.operation <= op;
    item_if.pixel_x   <= x;
    item_if.pixel_y   <= y;
    item_if.red_in    <= red;
    item_if.green_in  <= green;
    item_if.blue_in   <= blue;
    item_if.valid     <= 1'b1;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [lmrs_pkg::ColorW-1:0] random_level();
    if ($urandom_range(0, 2) == 0) return ColorOff;
    return lmrs_pkg::ColorW'($urandom_range(0, 255));
  endfunction

  // Mostly on-panel pixels and ticks; some off-panel writes, fills and
  // unused codes.
  task automatic send_random();
    int                          pick;
    logic [lmrs_pkg::CoordW-1:0] x;
    logic [lmrs_pkg::CoordW-1:0] y;
    pick = $urandom_range(0, 99);
    x    = lmrs_pkg::CoordW'($urandom_range(0, 255));
    y    = lmrs_pkg::CoordW'($urandom_range(0, 255));
    if (pick < 45) begin
      send_word(lmrs_pkg::OP_SET_PIXEL,
                lmrs_pkg::CoordW'($urandom_range(0, Width - 1)),
                lmrs_pkg::CoordW'($urandom_range(0, Height - 1)),
                random_level(), random_level(), random_level());
    end else if (pick < 53) begin
      send_word(lmrs_pkg::OP_SET_PIXEL, x, y, random_level(), random_level(),
                random_level());
    end else if (pick < 56) begin
      send_word(lmrs_pkg::OP_FILL, x, y, random_level(), random_level(), random_level());
    end else if (pick < 60) begin
      send_word(OpUnused, x, y, random_level(), random_level(), random_level());
    end else begin
      send_word(lmrs_pkg::OP_TICK, x, y, random_level(), random_level(), random_level());
    end
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n % 25) >= 19;
      send_random();
    end
    quiet = 1'b0;
  endtask

  task automatic write_scan_enable(logic value);
    scan_enable_we    <= 1'b1;
    scan_enable_wdata <= value;
    @(negedge clk_i);
    scan_enable_we    <= 1'b0;
  endtask

  // Drain all column words, then give a possible fill sweep time to finish.
  task automatic settle_and_configure(logic value);
    item_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PauseCycles) @(negedge clk_i);
    write_scan_enable(value);
  endtask

  initial begin : drain_columns
    int stall;
    int holds_served;
    holds_served = 0;
    result_if.ready <= 1'b0;
    @(negedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall        = stall + HoldCycles;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    item_if.valid     <= 1'b0;
    item_if.operation <= lmrs_pkg::OP_SET_PIXEL;
    item_if.pixel_x   <= '0;
    item_if.pixel_y   <= '0;
    item_if.red_in    <= ColorOff;
    item_if.green_in  <= ColorOff;
    item_if.blue_in   <= ColorOff;
    scan_enable_we    <= 1'b0;
    scan_enable_wdata <= 1'b0;
    rst_ni            <= 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_scan_enable(1'b0);

    // Scanning off: tick and unused code are dropped.
    send_word(lmrs_pkg::OP_TICK, 8'd0, 8'd0, ColorFull, ColorFull, ColorFull);
    send_word(OpUnused, 8'hff, 8'hff, ColorFull, ColorFull, ColorFull);
    settle_and_configure(1'b1);

    send_word(lmrs_pkg::OP_TICK, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);
    send_word(lmrs_pkg::OP_SET_PIXEL, 8'd0, 8'd0, 8'h01, ColorOff, ColorOff);
    send_word(lmrs_pkg::OP_SET_PIXEL, lmrs_pkg::CoordW'(Width - 1),
              lmrs_pkg::CoordW'(Height - 1), ColorFull, ColorFull, ColorFull);
    send_word(lmrs_pkg::OP_SET_PIXEL, lmrs_pkg::CoordW'(Width - 1),
              lmrs_pkg::CoordW'(Height / 2), ColorOff, ColorOff, 8'h80);
    send_word(lmrs_pkg::OP_SET_PIXEL, 8'd5, lmrs_pkg::CoordW'(Height / 2),
              ColorOff, 8'h01, ColorOff);
    // Off-panel writes must leave the store alone.
    send_word(lmrs_pkg::OP_SET_PIXEL, lmrs_pkg::CoordW'(Width), 8'd0,
              ColorFull, ColorFull, ColorFull);
    send_word(lmrs_pkg::OP_SET_PIXEL, 8'd0, lmrs_pkg::CoordW'(Height),
              ColorFull, ColorFull, ColorFull);
    send_word(lmrs_pkg::OP_SET_PIXEL, 8'hff, 8'hff, ColorFull, ColorFull, ColorFull);
    send_word(lmrs_pkg::OP_TICK, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);
    send_word(OpUnused, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);
    send_word(lmrs_pkg::OP_FILL, 8'd0, 8'd0, ColorOff, ColorFull, ColorOff);
    send_word(lmrs_pkg::OP_SET_PIXEL, 8'd10, lmrs_pkg::CoordW'(Height / 2 - 1),
              ColorOff, ColorOff, ColorOff);
    send_word(lmrs_pkg::OP_TICK, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);

    // Hold the output off while ticks keep coming, so the input backs up.
    hold_requests++;
    quiet = 1'b1;
    repeat (4) send_word(lmrs_pkg::OP_TICK, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);
    quiet = 1'b0;

    send_word(lmrs_pkg::OP_FILL, 8'hff, 8'hff, ColorFull, ColorFull, ColorFull);
    send_word(lmrs_pkg::OP_TICK, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);
    send_word(lmrs_pkg::OP_FILL, 8'd0, 8'd0, ColorOff, ColorOff, ColorOff);

    run_random(40);
    settle_and_configure(1'b0);
    run_random(20);
    settle_and_configure(1'b1);
    run_random(48);

    item_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lmrs_pkg.sv
hw/rtl/lmrs_item_if.sv
hw/rtl/lmrs_result_if.sv
hw/rtl/lmrs_frame_store.sv
hw/rtl/led_matrix_row_scanner.sv
sim/lmrs_checker.sv
sim/tb.sv
